// ----- hdl/ilst_pkg.sv -----
// Shared types and constants of the indexed ordered list.
`default_nettype none

package ilst_pkg;

  // Fixed field widths of the request and result items
  localparam int MODE_W = 3;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;

  // Depth of the queues between the front, the back and the result port
  localparam int QUEUE_DEPTH = 2;

  // Request mode codes as they arrive on the input
  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_READ   = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  // Operation after decode; undefined modes become OP_BAD
  typedef enum logic [2:0] {
    OP_APPEND,
    OP_INSERT,
    OP_REMOVE,
    OP_READ,
    OP_CLEAR,
    OP_BAD
  } op_e;

  // Request item
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] data_in;
  } list_req_t;

  // Result item
  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              bad_request;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
  } list_res_t;

  // Decoded command from front to back
  typedef struct packed {
    op_e               op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] data_in;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/ilst_fifo.sv -----
// Short queue of items with push/full and pop/empty handshakes.
`default_nettype none

module ilst_fifo #(
  parameter type ItemT = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      full_o,
  input  wire ItemT data_i,
  input  wire logic pop_i,
  output logic      empty_o,
  output ItemT      data_o
);

  localparam int PtrW = (ilst_pkg::QUEUE_DEPTH > 1) ? $clog2(ilst_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(ilst_pkg::QUEUE_DEPTH + 1);

  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  ItemT            mem_q [ilst_pkg::QUEUE_DEPTH];
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(ilst_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Pointer wrap and occupancy
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(ilst_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(ilst_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Item storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ilst_front.sv -----
// Front end: classifies each request item into a list command.
`default_nettype none

module ilst_front (
  input  wire ilst_pkg::list_req_t req_i,
  output ilst_pkg::cmd_t           cmd_o
);

  // Mode decode; unused codes are refused later by the back end
  always_comb begin
    cmd_o.position = req_i.position;
    cmd_o.data_in  = req_i.data_in;
    unique case (req_i.mode)
      ilst_pkg::MODE_APPEND: cmd_o.op = ilst_pkg::OP_APPEND;
      ilst_pkg::MODE_INSERT: cmd_o.op = ilst_pkg::OP_INSERT;
      ilst_pkg::MODE_REMOVE: cmd_o.op = ilst_pkg::OP_REMOVE;
      ilst_pkg::MODE_READ:   cmd_o.op = ilst_pkg::OP_READ;
      ilst_pkg::MODE_CLEAR:  cmd_o.op = ilst_pkg::OP_CLEAR;
      default:               cmd_o.op = ilst_pkg::OP_BAD;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/ilst_back.sv -----
// Back end: list storage, index checks, parallel shift and result build.
`default_nettype none

module ilst_back #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_empty_i,
  input  wire ilst_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output ilst_pkg::list_res_t res_o
);

  localparam int FillW = $clog2(DEPTH + 1);
  localparam int CmpW  = (FillW > ilst_pkg::POS_W) ? FillW : ilst_pkg::POS_W;

  logic [FillW-1:0] fill_q, fill_d;
  logic [WIDTH-1:0] ent_q [DEPTH];
  logic [WIDTH-1:0] ent_d [DEPTH];

  logic             exec;
  logic [CmpW-1:0]  pos_x, fill_x, ins_at;
  logic             is_full, do_ins, do_rem, rd_ok, bad;
  logic [WIDTH-1:0] word, rd_word;
  logic [WIDTH+ilst_pkg::DATA_W-1:0] in_ext, rd_ext;
  logic [FillW+ilst_pkg::CNT_W-1:0]  cnt_ext;

  // One command per cycle while there is room for its result
  assign exec       = !cmd_empty_i && !res_full_i;
  assign cmd_pop_o  = exec;
  assign res_push_o = exec;

  assign pos_x   = CmpW'(cmd_i.position);
  assign fill_x  = CmpW'(fill_q);
  assign is_full = (fill_q == FillW'(DEPTH));
  assign in_ext  = {{WIDTH{1'b0}}, cmd_i.data_in};
  assign word    = in_ext[WIDTH-1:0];

  // Index checks and count update
  always_comb begin
    do_ins = 1'b0;
    do_rem = 1'b0;
    rd_ok  = 1'b0;
    bad    = 1'b0;
    ins_at = fill_x;
    fill_d = fill_q;
    unique case (cmd_i.op)
      ilst_pkg::OP_APPEND: begin
        if (is_full) bad = 1'b1;
        else do_ins = 1'b1;
      end
      ilst_pkg::OP_INSERT: begin
        // empty list takes the word at element 0 whatever the index
        if (fill_q == '0) begin
          do_ins = 1'b1;
          ins_at = '0;
        end else if (is_full || pos_x > fill_x) begin
          bad = 1'b1;
        end else begin
          do_ins = 1'b1;
          ins_at = pos_x;
        end
      end
      ilst_pkg::OP_REMOVE: begin
        if (pos_x >= fill_x) bad = 1'b1;
        else do_rem = 1'b1;
      end
      ilst_pkg::OP_READ: begin
        if (pos_x >= fill_x) bad = 1'b1;
        else rd_ok = 1'b1;
      end
      ilst_pkg::OP_CLEAR: fill_d = '0;
      default: bad = 1'b1;
    endcase
    if (do_ins) fill_d = fill_q + FillW'(1);
    if (do_rem) fill_d = fill_q - FillW'(1);
  end

  // Per-entry next value: shift up on insert, shift down on remove
  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    logic [WIDTH-1:0] up_src, dn_src;
    logic             up_ok, dn_ok;
    if (g == 0) begin : g_first
      assign up_src = word;
      assign up_ok  = 1'b0;
    end else begin : g_rest
      assign up_src = ent_q[g-1];
      assign up_ok  = (CmpW'(g) > ins_at) && (CmpW'(g) <= fill_x);
    end
    if (g == DEPTH - 1) begin : g_last
      assign dn_src = ent_q[g];
      assign dn_ok  = 1'b0;
    end else begin : g_inner
      assign dn_src = ent_q[g+1];
      assign dn_ok  = (CmpW'(g) >= pos_x) && (CmpW'(g + 1) < fill_x);
    end
    always_comb begin
      if (do_ins && CmpW'(g) == ins_at) ent_d[g] = word;
      else if (do_ins && up_ok)         ent_d[g] = up_src;
      else if (do_rem && dn_ok)         ent_d[g] = dn_src;
      else                              ent_d[g] = ent_q[g];
    end
  end

  // Read select
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CmpW'(i) == pos_x) rd_word = ent_q[i];
    end
  end

  assign rd_ext  = {{ilst_pkg::DATA_W{1'b0}}, rd_word};
  assign cnt_ext = {{ilst_pkg::CNT_W{1'b0}}, fill_d};

  // Result item
  always_comb begin
    res_o.data_out    = rd_ok ? rd_ext[ilst_pkg::DATA_W-1:0] : '0;
    res_o.bad_request = bad;
    res_o.count       = cnt_ext[ilst_pkg::CNT_W-1:0];
    res_o.is_empty    = (fill_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (exec) begin
      fill_q <= fill_d;
    end
  end

  // Entries hold data only; no reset
  always_ff @(posedge clk_i) begin
    if (exec) begin
      ent_q <= ent_d;
    end
  end

  // Count never passes the depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(DEPTH))
    else $error("list count above depth");

  // A refused command leaves the count alone
  a_bad_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && bad |=> fill_q == $past(fill_q))
    else $error("refused command changed the count");

  // Clear empties the list
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && cmd_i.op == ilst_pkg::OP_CLEAR |=> fill_q == '0)
    else $error("clear left entries");

  // An accepted append or insert grows the list by one
  a_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && !bad && (cmd_i.op == ilst_pkg::OP_APPEND || cmd_i.op == ilst_pkg::OP_INSERT)
    |=> fill_q == $past(fill_q) + FillW'(1))
    else $error("insert did not grow the list");

endmodule

`default_nettype wire

// ----- hdl/indexed_ordered_list.sv -----
// A request is registered in the command queue; the back end executes it and registers
//   its result in the result queue, where it stays on the result ports until popped.
// Throughput: one request per cycle while results are popped; the back end executes
//   each command, shifting all later entries in parallel.
// Reset clears the element count and empties both queues; entry data is not cleared.
// Requests and results each pass a two-item queue, so either side may stall alone.
`default_nettype none

module indexed_ordered_list #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire ilst_pkg::list_req_t req_i,
  output logic                     empty,
  input  wire logic                pop,
  output ilst_pkg::list_res_t      res_o
);

  ilst_pkg::cmd_t      cmd_in, cmd_out;
  ilst_pkg::list_res_t res_in;
  logic                cmd_empty, cmd_pop, res_full, res_push;

  // Request decode
  ilst_front u_front (
    .req_i (req_i),
    .cmd_o (cmd_in)
  );

  // Command queue between front and back
  ilst_fifo #(.ItemT(ilst_pkg::cmd_t)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  // List storage and execution
  ilst_back #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue
  ilst_fifo #(.ItemT(ilst_pkg::list_res_t)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_o)
  );

endmodule

`default_nettype wire
